// File: hw/rtl/brrip_pkg.sv
// ============================================================================
// brrip_pkg: shared types and constants for the bandit RRIP replacement block
// Geometry, request codes, controller states and the command/status structs.
// ============================================================================
`default_nettype none

package brrip_pkg;

  localparam int unsigned NumSets   = 2048;
  localparam int unsigned NumWays   = 16;
  localparam int unsigned RrpvBits  = 2;
  localparam int unsigned NumArms   = 3;
  localparam int unsigned SetBits   = 11;
  localparam int unsigned WayBits   = 4;
  localparam int unsigned CntBits   = 16;
  localparam int unsigned RowBits   = NumWays * RrpvBits;
  localparam int unsigned ArmRowBits = NumWays * 2;
  localparam int unsigned CntRowBits = NumArms * CntBits;
  localparam logic [RrpvBits-1:0] RrpvTop = '1;
  localparam logic [15:0] GainReset = 16'd4096;
  localparam logic [15:0] Ln2Q16 = 16'd45426;

  typedef enum logic [1:0] {
    REQ_VICTIM = 2'd0,
    REQ_HIT    = 2'd1,
    REQ_FILL   = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DECODE,
    ST_LOG,
    ST_LN,
    ST_ARM_DIV,
    ST_ARM_SQRT,
    ST_ARM_MUL,
    ST_WRITE,
    ST_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic clear_step;   // write reset row at clear pointer
    logic capture;      // latch request
    logic read;         // issue memory reads
    logic log_start;
    logic log_step;
    logic ln_calc;
    logic div_start;
    logic div_step;
    logic sqrt_start;
    logic sqrt_step;
    logic ucb_calc;     // compute ucb of current arm and compare
    logic arm_next;
    logic write;        // update memories, load result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_done;
    logic untried;      // some arm of the set has zero selections
    logic needs_pick;   // request is a valid fill
    logic log_done;
    logic div_done;
    logic sqrt_done;
    logic last_arm;
  } dp_sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/brrip_ctrl.sv
// ============================================================================
// brrip_ctrl: controller state machine
// Sequences clearing, memory read, log, per-arm divide/sqrt/ucb and writeback.
// ============================================================================
`default_nettype none

module brrip_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             req_valid_i,
  output logic                  req_ready_o,
  output logic                  rsp_valid_o,
  input  wire logic             rsp_ready_i,
  input  wire brrip_pkg::dp_sts_t sts_i,
  output brrip_pkg::dp_cmd_t    cmd_o
);
  import brrip_pkg::*;

  state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:    if (sts_i.clear_done) state_d = ST_IDLE;
      ST_IDLE:     if (req_valid_i) state_d = ST_READ;
      ST_READ:     state_d = ST_DECODE;
      ST_DECODE:   state_d = (sts_i.needs_pick && !sts_i.untried) ? ST_LOG : ST_WRITE;
      ST_LOG:      if (sts_i.log_done) state_d = ST_LN;
      ST_LN:       state_d = ST_ARM_DIV;
      ST_ARM_DIV:  if (sts_i.div_done) state_d = ST_ARM_SQRT;
      ST_ARM_SQRT: if (sts_i.sqrt_done) state_d = ST_ARM_MUL;
      ST_ARM_MUL:  state_d = sts_i.last_arm ? ST_WRITE : ST_ARM_DIV;
      ST_WRITE:    state_d = ST_OUT;
      ST_OUT: begin
        if (rsp_ready_i) state_d = ST_IDLE;
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    rsp_valid_o = 1'b0;
    case (state_q)
      ST_CLEAR:    cmd_o.clear_step = 1'b1;
      ST_IDLE: begin
        req_ready_o   = 1'b1;
        cmd_o.capture = req_valid_i;
      end
      ST_READ:     cmd_o.read = 1'b1;
      ST_DECODE:   cmd_o.log_start = 1'b1;
      ST_LOG:      cmd_o.log_step = 1'b1;
      ST_LN: begin
        cmd_o.ln_calc   = 1'b1;
        cmd_o.div_start = 1'b1;
      end
      ST_ARM_DIV: begin
        cmd_o.div_step   = 1'b1;
        cmd_o.sqrt_start = sts_i.div_done;
      end
      ST_ARM_SQRT: cmd_o.sqrt_step = 1'b1;
      ST_ARM_MUL: begin
        cmd_o.ucb_calc  = 1'b1;
        cmd_o.arm_next  = 1'b1;
        cmd_o.div_start = !sts_i.last_arm;
      end
      ST_WRITE:    cmd_o.write = 1'b1;
      ST_OUT:      rsp_valid_o = 1'b1;
      default:     cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // no transaction taken while clearing or busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_ready_o |-> state_q == ST_IDLE) else $error("ready outside idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_ready_i) |=> rsp_valid_o) else $error("response dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_ready_o && rsp_valid_o)) else $error("overlap of request and response");

endmodule

`default_nettype wire

// File: hw/rtl/brrip_dp.sv
// ============================================================================
// brrip_dp: datapath
// Row memories for RRPV, arm tags and counters, plus iterative log2, divider,
// square root and the UCB compare.
// ============================================================================
`default_nettype none

module brrip_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire brrip_pkg::dp_cmd_t            cmd_i,
  output brrip_pkg::dp_sts_t                 sts_o,
  input  wire logic [15:0]                   explore_gain_i,
  input  wire logic [1:0]                    req_type_i,
  input  wire logic [brrip_pkg::SetBits-1:0] set_index_i,
  input  wire logic [brrip_pkg::WayBits-1:0] way_index_i,
  output logic [brrip_pkg::WayBits-1:0]      victim_way_o,
  output logic [1:0]                         chosen_arm_o
);
  import brrip_pkg::*;

  // memories, one row per set
  logic [RowBits-1:0]    rrpv_mem [NumSets];
  logic [ArmRowBits-1:0] tag_mem  [NumSets];
  logic [CntRowBits-1:0] sel_mem  [NumSets];
  logic [CntRowBits-1:0] hit_mem  [NumSets];

  logic [RowBits-1:0]    rrpv_row_q;
  logic [ArmRowBits-1:0] tag_row_q;
  logic [CntRowBits-1:0] sel_row_q;
  logic [CntRowBits-1:0] hit_row_q;

  logic [1:0]         req_q;
  logic [SetBits-1:0] set_q;
  logic [WayBits-1:0] way_q;
  logic [SetBits:0]   clr_q;

  // clearing pass pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_step && !clr_q[SetBits]) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_type_i;
      set_q <= set_index_i;
      way_q <= way_index_i;
    end
  end

  // row data helpers
  logic [RrpvBits-1:0] rrpv_w [NumWays];
  logic [RrpvBits-1:0] top_rrpv;
  logic [RrpvBits-1:0] age;
  logic [RowBits-1:0]  aged_row;
  logic [WayBits-1:0]  vict;
  logic                vict_found;
  logic [CntBits-1:0]  sel_a [NumArms];
  logic [CntBits-1:0]  hit_a [NumArms];
  logic [1:0]          hit_tag;
  logic [1:0]          untried_arm;
  logic                any_untried;

  always_comb begin
    top_rrpv = '0;
    for (int w = 0; w < NumWays; w++) begin
      rrpv_w[w] = rrpv_row_q[w*RrpvBits +: RrpvBits];
      if (rrpv_w[w] > top_rrpv) top_rrpv = rrpv_w[w];
    end
    age = RrpvTop - top_rrpv;
    aged_row = '0;
    for (int w = 0; w < NumWays; w++) begin
      aged_row[w*RrpvBits +: RrpvBits] = rrpv_w[w] + age;
    end
    vict = '0;
    vict_found = 1'b0;
    for (int w = 0; w < NumWays; w++) begin
      if (!vict_found && (rrpv_w[w] + age) == RrpvTop) begin
        vict = WayBits'(w);
        vict_found = 1'b1;
      end
    end
    for (int a = 0; a < NumArms; a++) begin
      sel_a[a] = sel_row_q[a*CntBits +: CntBits];
      hit_a[a] = hit_row_q[a*CntBits +: CntBits];
    end
    hit_tag = tag_row_q[way_q*2 +: 2];
    any_untried = 1'b0;
    untried_arm = 2'd0;
    for (int a = NumArms - 1; a >= 0; a--) begin
      if (sel_a[a] == '0) begin
        any_untried = 1'b1;
        untried_arm = 2'(a);
      end
    end
  end

  // ---------------- log2 of total ----------------
  logic [17:0] total;
  logic [4:0]  lead;
  logic [17:0] mant_q;   // Q1.16 plus headroom
  logic [4:0]  lg_int_q;
  logic [15:0] lg_frac_q;
  logic [4:0]  lg_cnt_q;
  logic [35:0] sq;
  logic [31:0] ln_d;
  logic [31:0] ln_q;

  always_comb begin
    total = 18'(sel_a[0]) + 18'(sel_a[1]) + 18'(sel_a[2]);
    lead = '0;
    for (int b = 0; b < 18; b++) begin
      if (total[b]) lead = 5'(b);
    end
    sq = 36'(mant_q) * 36'(mant_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.log_start) begin
      mant_q    <= 18'((34'(total) << 16) >> lead);
      lg_int_q  <= lead;
      lg_frac_q <= '0;
      lg_cnt_q  <= 5'd16;
    end else if (cmd_i.log_step && lg_cnt_q != '0) begin
      lg_cnt_q <= lg_cnt_q - 1'b1;
      if (sq[35:16] >= 20'h20000) begin
        mant_q <= 18'(sq[35:17]);
        lg_frac_q[4'(lg_cnt_q - 1'b1)] <= 1'b1;
      end else begin
        mant_q <= sq[33:16];
      end
    end
  end

  // ln = lg * ln2 >> 16
  assign ln_d = 32'((({lg_int_q, lg_frac_q}) * 37'(Ln2Q16)) >> 16);

  always_ff @(posedge clk_i) begin
    if (cmd_i.ln_calc) begin
      ln_q <= ln_d;
    end
  end

  // ---------------- per-arm divider ----------------
  // two quotients at once: mean = hit<<16 / sel, q = ln / sel
  logic [1:0]  arm_q;
  logic [CntBits-1:0] dsel;
  logic [31:0] mean_n_q, mean_r_q, q_n_q, q_r_q;
  logic [5:0]  div_cnt_q;
  logic [32:0] mr_sh, qr_sh;

  assign dsel  = sel_a[arm_q];
  assign mr_sh = {mean_r_q, mean_n_q[31]};
  assign qr_sh = {q_r_q, q_n_q[31]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      mean_n_q  <= {hit_a[cmd_i.arm_next ? 2'(arm_q + 1'b1) : 2'd0], 16'd0};
      // first arm starts in the same cycle that ln is registered
      q_n_q     <= cmd_i.ln_calc ? ln_d : ln_q;
      mean_r_q  <= '0;
      q_r_q     <= '0;
      div_cnt_q <= 6'd32;
    end else if (cmd_i.div_step && div_cnt_q != '0) begin
      div_cnt_q <= div_cnt_q - 1'b1;
      if (mr_sh >= 33'(dsel)) begin
        mean_r_q <= 32'(mr_sh - 33'(dsel));
        mean_n_q <= {mean_n_q[30:0], 1'b1};
      end else begin
        mean_r_q <= mr_sh[31:0];
        mean_n_q <= {mean_n_q[30:0], 1'b0};
      end
      if (qr_sh >= 33'(dsel)) begin
        q_r_q <= 32'(qr_sh - 33'(dsel));
        q_n_q <= {q_n_q[30:0], 1'b1};
      end else begin
        q_r_q <= qr_sh[31:0];
        q_n_q <= {q_n_q[30:0], 1'b0};
      end
    end
  end

  // ---------------- square root of q<<16 (48-bit radicand) ----------------
  logic [47:0] sq_v_q, sq_r_q, sq_b_q;
  logic [48:0] trial;
  logic        sq_busy;

  assign trial   = 49'(sq_r_q) + 49'(sq_b_q);
  assign sq_busy = sq_b_q != '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_start) begin
      sq_v_q <= {q_n_q[31:0], 16'd0};
      sq_r_q <= '0;
      sq_b_q <= 48'h4000_0000_0000;
    end else if (cmd_i.sqrt_step && sq_busy) begin
      if (49'(sq_v_q) >= trial) begin
        sq_v_q <= 48'(49'(sq_v_q) - trial);
        sq_r_q <= (sq_r_q >> 1) + sq_b_q;
      end else begin
        sq_r_q <= sq_r_q >> 1;
      end
      sq_b_q <= sq_b_q >> 2;
    end
  end

  // ---------------- ucb and best arm ----------------
  logic [47:0] ucb;
  logic [47:0] best_q;
  logic [1:0]  best_arm_q;

  assign ucb = 48'(mean_n_q) + 48'((40'(explore_gain_i) * 40'(sq_r_q[23:0])) >> 12);

  always_ff @(posedge clk_i) begin
    if (cmd_i.log_start) begin
      arm_q <= '0;
    end else if (cmd_i.arm_next) begin
      arm_q <= arm_q + 1'b1;
    end
    if (cmd_i.ucb_calc && (arm_q == 2'd0 || ucb > best_q)) begin
      best_q     <= ucb;
      best_arm_q <= arm_q;
    end
  end

  // ---------------- memories ----------------
  logic       ok_set, ok_way;
  logic [1:0] fill_arm;
  logic [RrpvBits-1:0] ins_rrpv;
  logic [RowBits-1:0]    rrpv_new;
  logic [ArmRowBits-1:0] tag_new;
  logic [CntRowBits-1:0] sel_new, hit_new;

  always_comb begin
    ok_set   = 32'(set_q) < NumSets && req_q != REQ_NONE;
    ok_way   = 32'(way_q) < NumWays;
    fill_arm = any_untried ? untried_arm : best_arm_q;
    ins_rrpv = fill_arm == 2'd0 ? '0 : (fill_arm == 2'd1 ? RrpvBits'(1) : RrpvTop);
    rrpv_new = rrpv_row_q;
    tag_new  = tag_row_q;
    sel_new  = sel_row_q;
    hit_new  = hit_row_q;
    if (req_q == REQ_VICTIM) begin
      rrpv_new = aged_row;
    end else if (req_q == REQ_HIT) begin
      rrpv_new[way_q*RrpvBits +: RrpvBits] = '0;
      if (hit_tag != 2'd3) begin
        hit_new[hit_tag*CntBits +: CntBits] = hit_a[hit_tag] + 1'b1;
      end
    end else begin
      rrpv_new[way_q*RrpvBits +: RrpvBits] = ins_rrpv;
      tag_new[way_q*2 +: 2] = fill_arm;
      sel_new[fill_arm*CntBits +: CntBits] = sel_a[fill_arm] + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_step && !clr_q[SetBits]) begin
      rrpv_mem[clr_q[SetBits-1:0]] <= '1;
      tag_mem[clr_q[SetBits-1:0]]  <= {NumWays{2'd1}};
      sel_mem[clr_q[SetBits-1:0]]  <= '0;
      hit_mem[clr_q[SetBits-1:0]]  <= '0;
    end else if (cmd_i.write && ok_set && (req_q == REQ_VICTIM || ok_way)) begin
      rrpv_mem[set_q] <= rrpv_new;
      tag_mem[set_q]  <= tag_new;
      sel_mem[set_q]  <= sel_new;
      hit_mem[set_q]  <= hit_new;
    end
    if (cmd_i.read) begin
      rrpv_row_q <= rrpv_mem[set_q];
      tag_row_q  <= tag_mem[set_q];
      sel_row_q  <= sel_mem[set_q];
      hit_row_q  <= hit_mem[set_q];
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      victim_way_o <= (ok_set && req_q == REQ_VICTIM) ? vict : '0;
      chosen_arm_o <= (ok_set && ok_way && req_q == REQ_FILL) ? fill_arm : '0;
    end
  end

  assign sts_o.clear_done = clr_q[SetBits];
  assign sts_o.untried    = any_untried;
  assign sts_o.needs_pick = ok_set && ok_way && req_q == REQ_FILL;
  assign sts_o.log_done   = lg_cnt_q == '0;
  assign sts_o.div_done   = div_cnt_q == '0;
  assign sts_o.sqrt_done  = !sq_busy;
  assign sts_o.last_arm   = arm_q == 2'(NumArms - 1);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ucb_calc |-> arm_q < 2'(NumArms)) else $error("arm index out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write |-> clr_q[SetBits]) else $error("write before clear done");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sqrt_start |-> div_cnt_q == '0) else $error("sqrt before divide done");

endmodule

`default_nettype wire

// File: hw/rtl/bandit_rrip_replacement.sv
// Flow: victim query and hit go through read, decode, write and the result transaction;
// a fill with all arms tried also runs log2 and a per-arm divide and root (two 32-step dividers run
// together, a 24-step square root per arm, 16 log2 squaring steps).
// Throughput: one transaction at a time; the next is taken after the result leaves.
// Reset: a clearing pass, one set row per cycle, blocks requests.
// ============================================================================
// bandit_rrip_replacement: RRIP replacement state with UCB1 insertion choice
// Top level joining the controller and datapath, plus the gain register.
// ============================================================================
`default_nettype none

module bandit_rrip_replacement (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        req_valid_i,
  output logic             req_ready_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [brrip_pkg::SetBits-1:0] set_index_i,
  input  wire logic [brrip_pkg::WayBits-1:0] way_index_i,
  output logic             rsp_valid_o,
  input  wire logic        rsp_ready_i,
  output logic [brrip_pkg::WayBits-1:0] victim_way_o,
  output logic [1:0]       chosen_arm_o
);
  import brrip_pkg::*;

  logic [15:0] explore_gain_q;
  dp_cmd_t     cmd;
  dp_sts_t     sts;

  // exploration gain register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      explore_gain_q <= GainReset;
    end else if (cfg_we_i) begin
      explore_gain_q <= cfg_wdata_i;
    end
  end

  brrip_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .req_valid_i,
    .req_ready_o,
    .rsp_valid_o,
    .rsp_ready_i,
    .sts_i (sts),
    .cmd_o (cmd)
  );

  brrip_dp u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i          (cmd),
    .sts_o          (sts),
    .explore_gain_i (explore_gain_q),
    .req_type_i,
    .set_index_i,
    .way_index_i,
    .victim_way_o,
    .chosen_arm_o
  );

endmodule

`default_nettype wire

// File: test/tb_bandit_rrip_replacement.sv
// ============================================================================
// tb_bandit_rrip_replacement: self-checking testbench for the replacement block
// Drives victim, hit, fill and no-op requests with random idling on both channels,
// predicts every response with a behavioral model of the RRIP state and the
// UCB1 arm choice, and compares the responses in order.
// ============================================================================
`default_nettype none

module tb_bandit_rrip_replacement;
  timeunit 1ns;
  timeprecision 1ps;

  import brrip_pkg::*;

  localparam int unsigned WatchLimit = 20000;
  localparam int unsigned NumRandom  = 2000;
  localparam int unsigned SetCount   = 1 << SetBits;

  typedef struct packed {
    logic [3:0] victim;
    logic [1:0] arm;
  } rsp_t;

  typedef struct {
    req_e        kind;
    logic [10:0] set;
    logic [3:0]  way;
    logic        known;   // expected response typed in
    rsp_t        rsp;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        req_valid_i = 1'b0;
  logic        req_ready_o;
  logic [1:0]  req_type_i = '0;
  logic [SetBits-1:0] set_index_i = '0;
  logic [WayBits-1:0] way_index_i = '0;
  logic        rsp_valid_o;
  logic        rsp_ready_i = 1'b0;
  logic [WayBits-1:0] victim_way_o;
  logic [1:0]  chosen_arm_o;

  bandit_rrip_replacement dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .req_valid_i, .req_ready_o, .req_type_i, .set_index_i, .way_index_i,
    .rsp_valid_o, .rsp_ready_i, .victim_way_o, .chosen_arm_o
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [1:0]  rrpv_mem [SetCount*NumWays];
  logic [1:0]  tag_mem  [SetCount*NumWays];
  logic [15:0] sel_cnt  [SetCount*NumArms];
  logic [15:0] hit_cnt  [SetCount*NumArms];
  logic [15:0] gain;

  rsp_t        rsp_queue [$];
  int unsigned errors = 0;
  int unsigned n_rsp = 0, n_fill = 0, n_victim = 0, n_hit = 0;
  int unsigned idle_cycles = 0;
  logic        hold_off = 1'b0;

  function automatic logic [63:0] log2_fixed(logic [63:0] x);
    int unsigned k;
    logic [63:0] m, res;
    k = 0;
    while (k < 40 && (x >> (k + 1)) != 0) k++;
    m = (x << 16) >> k;
    res = 64'(k) << 16;
    for (int i = 15; i >= 0; i--) begin
      m = (m * m) >> 16;
      if (m >= (64'd1 << 17)) begin
        m = m >> 1;
        res[i] = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic logic [63:0] root_fixed(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [1:0] ucb_arm(int unsigned s);
    logic [63:0] total, lnq, best, mean, rt, score, sc;
    logic [1:0]  pick;
    best = 0;
    pick = 0;
    for (int a = 0; a < NumArms; a++)
      if (sel_cnt[s*NumArms+a] == 0) return 2'(a);
    total = 64'(sel_cnt[s*NumArms]) + sel_cnt[s*NumArms+1] + sel_cnt[s*NumArms+2];
    lnq = (log2_fixed(total) * 64'(Ln2Q16)) >> 16;
    for (int a = 0; a < NumArms; a++) begin
      sc = 64'(sel_cnt[s*NumArms+a]);
      mean = (64'(hit_cnt[s*NumArms+a]) << 16) / sc;
      rt = root_fixed((lnq / sc) << 16);
      score = mean + ((64'(gain) * rt) >> 12);
      if (a == 0 || score > best) begin
        best = score;
        pick = 2'(a);
      end
    end
    return pick;
  endfunction

  // apply one request to the predictor, return the expected response
  function automatic rsp_t replace_update(logic [1:0] kind, logic [10:0] s, logic [3:0] w);
    rsp_t r;
    int unsigned top, base, a;
    r = '0;
    base = s * NumWays;
    if (kind == REQ_NONE || s >= NumSets) return r;
    if (kind == REQ_VICTIM) begin
      top = 0;
      for (int i = 0; i < NumWays; i++) if (rrpv_mem[base+i] > top) top = rrpv_mem[base+i];
      if (top < RrpvTop)
        for (int i = 0; i < NumWays; i++) rrpv_mem[base+i] += 2'(RrpvTop - top);
      r.victim = 4'(NumWays);
      for (int i = NumWays - 1; i >= 0; i--)
        if (rrpv_mem[base+i] == RrpvTop) r.victim = 4'(i);
      return r;
    end
    if (w >= NumWays) return r;
    if (kind == REQ_HIT) begin
      a = tag_mem[base+w];
      rrpv_mem[base+w] = 0;
      if (a < NumArms) hit_cnt[s*NumArms+a] += 16'd1;
      return r;
    end
    a = ucb_arm(s);
    sel_cnt[s*NumArms+a] += 16'd1;
    tag_mem[base+w] = 2'(a);
    rrpv_mem[base+w] = (a == 0) ? 2'd0 : (a == 1) ? 2'd1 : RrpvTop;
    r.arm = 2'(a);
    return r;
  endfunction

  task automatic reset_model();
    for (int i = 0; i < SetCount*NumWays; i++) begin
      rrpv_mem[i] = RrpvTop;
      tag_mem[i] = 2'd1;
    end
    for (int i = 0; i < SetCount*NumArms; i++) begin
      sel_cnt[i] = '0;
      hit_cnt[i] = '0;
    end
    gain = GainReset;
  endtask

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 5);
  endfunction

  // send one request and queue its expectation; optional typed-in check
  task automatic send_req(logic [1:0] kind, logic [10:0] s, logic [3:0] w,
                          logic known, rsp_t given);
    rsp_t e;
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      req_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_type_i <= kind;
    set_index_i <= s;
    way_index_i <= w;
    @(posedge clk_i);
    while (!req_ready_o) @(posedge clk_i);
    e = replace_update(kind, s, w);
    if (known && e !== given) begin
      errors++;
      if (errors <= 10)
        $display("table row disagrees with predictor: table %h model %h", given, e);
    end
    rsp_queue.push_back(e);
    if (kind == REQ_FILL) n_fill++;
    if (kind == REQ_VICTIM) n_victim++;
    if (kind == REQ_HIT) n_hit++;
  endtask

  task automatic drain();
    req_valid_i <= 1'b0;
    while (rsp_queue.size() != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
  endtask

  task automatic write_gain(logic [15:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    gain = v;
  endtask

  // response checker
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o && rsp_ready_i) begin
      rsp_t e;
      n_rsp++;
      if (rsp_queue.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected response %h/%h", victim_way_o, chosen_arm_o);
      end else begin
        e = rsp_queue.pop_front();
        if (victim_way_o !== e.victim || chosen_arm_o !== e.arm) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: victim exp %0d got %0d, arm exp %0d got %0d",
                     e.victim, victim_way_o, e.arm, chosen_arm_o);
        end
      end
    end
  end

  // receiver: random stalls plus a long hold-off when requested
  initial begin
    int unsigned g;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        rsp_ready_i <= 1'b0;
        for (int i = 0; i < 300; i++) @(posedge clk_i);
        hold_off = 1'b0;
      end
      g = gap_len();
      if (g == 0) begin
        rsp_ready_i <= 1'b1;
        @(posedge clk_i);
      end else begin
        rsp_ready_i <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((req_valid_i && req_ready_o) || (rsp_valid_o && rsp_ready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("tb_bandit_rrip_replacement NOT OK");
      $finish;
    end
  end

  row_t rows [$];

  initial begin
    logic [1:0] k;
    logic [10:0] s;
    reset_model();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: after reset the first victim is way 0, first fills try arms in order
    rows.push_back('{REQ_VICTIM, 11'd0,    4'd9,  1'b1, '{4'd0, 2'd0}});
    rows.push_back('{REQ_FILL,   11'd0,    4'd0,  1'b1, '{4'd0, 2'd0}});
    rows.push_back('{REQ_FILL,   11'd0,    4'd1,  1'b1, '{4'd0, 2'd1}});
    rows.push_back('{REQ_FILL,   11'd0,    4'd15, 1'b1, '{4'd0, 2'd2}});
    rows.push_back('{REQ_VICTIM, 11'd0,    4'd0,  1'b1, '{4'd2, 2'd0}});
    rows.push_back('{REQ_HIT,    11'd0,    4'd0,  1'b1, '{4'd0, 2'd0}});
    rows.push_back('{REQ_HIT,    11'd0,    4'd5,  1'b1, '{4'd0, 2'd0}});
    rows.push_back('{REQ_FILL,   11'd0,    4'd3,  1'b0, '0});
    rows.push_back('{REQ_FILL,   11'd0,    4'd4,  1'b0, '0});
    rows.push_back('{REQ_NONE,   11'd2047, 4'd15, 1'b1, '{4'd0, 2'd0}});
    rows.push_back('{REQ_FILL,   11'd2047, 4'd15, 1'b1, '{4'd0, 2'd0}});
    rows.push_back('{REQ_HIT,    11'd2047, 4'd15, 1'b1, '{4'd0, 2'd0}});
    rows.push_back('{REQ_VICTIM, 11'd2047, 4'd0,  1'b1, '{4'd0, 2'd0}});
    rows.push_back('{REQ_VICTIM, 11'd2047, 4'd0,  1'b0, '0});
    rows.push_back('{REQ_HIT,    11'd1024, 4'd7,  1'b0, '0});
    foreach (rows[i]) send_req(rows[i].kind, rows[i].set, rows[i].way, rows[i].known,
                               rows[i].rsp);
    drain();

    // random phases over several gain settings, a few hot sets so the bandit matures
    for (int p = 0; p < 4; p++) begin
      write_gain(p == 0 ? 16'd0 : p == 1 ? 16'hFFFF : p == 2 ? 16'd700 : GainReset);
      if (p == 1) hold_off = 1'b1;
      for (int i = 0; i < NumRandom / 4; i++) begin
        k = 2'($urandom_range(99) < 40 ? REQ_FILL : $urandom_range(2));
        if ($urandom_range(49) == 0) k = REQ_NONE;
        s = ($urandom_range(9) < 8) ? 11'($urandom_range(3)) : 11'($urandom);
        send_req(k, s, 4'($urandom), 1'b0, '0);
      end
      drain();
    end

    $display("ran %0d requests (%0d fills, %0d victims, %0d hits) over four gains",
             n_fill + n_victim + n_hit, n_fill, n_victim, n_hit);
    $display("%0d responses checked, %0d errors", n_rsp, errors);
    if (errors == 0 && rsp_queue.size() == 0) begin
      $display("tb_bandit_rrip_replacement OK");
    end else begin
      $display("tb_bandit_rrip_replacement NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
